FILE: sv/bpsc_pkg.sv
// Shared widths, types and codes for the box versus plane side classifier.
`default_nettype none

package bpsc_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int NORM_WIDTH  = 18;
	localparam int FRAC_BITS   = 16;
	localparam int PROD_WIDTH  = NORM_WIDTH + COORD_WIDTH;
	localparam int SUM_WIDTH   = PROD_WIDTH + 2;
	localparam int AXES        = 3;

	localparam int IN_WIDTH     = AXES * NORM_WIDTH + 7 * COORD_WIDTH;
	localparam int IN_TDATA_W   = ((IN_WIDTH + 7) / 8) * 8;
	localparam int SIDE_WIDTH   = 2;
	localparam int OUT_TDATA_W  = 8;

	localparam int OFF_DIST    = AXES * NORM_WIDTH;
	localparam int OFF_MIN     = OFF_DIST + COORD_WIDTH;
	localparam int OFF_MAX     = OFF_MIN + AXES * COORD_WIDTH;

	typedef logic signed [NORM_WIDTH-1:0]  norm_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [SUM_WIDTH-1:0]   sum_t;

	localparam norm_t ONE_Q = norm_t'(1 << FRAC_BITS);

	typedef enum logic [SIDE_WIDTH-1:0] {
		SIDE_NONE  = 2'd0,
		SIDE_FRONT = 2'd1,
		SIDE_BACK  = 2'd2,
		SIDE_BOTH  = 2'd3
	} side_t;

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
		logic adv_s4;
	} bpsc_adv_t;

endpackage

`default_nettype wire

FILE: sv/bpsc_dot.sv
// Pipelined exact sign test of a corner dot product against the plane distance.
`default_nettype none

module bpsc_dot
	import bpsc_pkg::*;
(
	input  wire logic      clk,
	input  wire bpsc_adv_t adv,
	input  wire norm_t     norm [AXES],
	input  wire coord_t    coord [AXES],
	input  wire coord_t    plane_dist,
	output logic           ge
);

	prod_t  prod_s2 [AXES];
	coord_t dist_s2;
	sum_t   sum_a_s3;
	sum_t   sum_b_s3;
	sum_t   total;
	logic   ge_s4;

	always_ff @(posedge clk) begin
		if (adv.adv_s2) begin
			for (int i = 0; i < AXES; i++) begin
				prod_s2[i] <= prod_t'(norm[i]) * prod_t'(coord[i]);
			end
			dist_s2 <= plane_dist;
		end
		if (adv.adv_s3) begin
			sum_a_s3 <= sum_t'(prod_s2[0]) + sum_t'(prod_s2[1]);
			sum_b_s3 <= sum_t'(prod_s2[2]) - (sum_t'(dist_s2) <<< FRAC_BITS);
		end
		if (adv.adv_s4) begin
			ge_s4 <= ~total[SUM_WIDTH-1];
		end
	end

	assign total = sum_a_s3 + sum_b_s3;
	assign ge    = ge_s4;

endmodule

`default_nettype wire

FILE: sv/box_plane_side_classify.sv
// Top level of the box versus plane side classifier.
//
// One input transaction on the s_ channel carries a plane (normal in Q2.16,
// distance in Q16.16) and an axis-aligned box (min and max corners in Q16.16).
// One output transaction on the m_ channel returns the side code: 1 front,
// 2 back, 3 straddling, 0 for a box with min above max in the general case.
// A normal component of exactly 1.0 makes the plane axial, the last such axis
// winning, and then only that axis's extent is compared with the distance.
// The pipeline has four register stages: corner selection, six parallel
// 18 by 32 multiplies, partial sums, and the final add with its sign test.
// A result is driven on m_tvalid from the fourth stage, and one transaction is
// accepted every cycle unless the pipeline is full and stalled. Each stage
// holds its item when the next one is full, so a stalled receiver backs the
// pipeline up stage by stage; s_tready falls only once all four stages hold
// items. Reset empties the pipeline; no state survives between items.
`default_nettype none

module box_plane_side_classify
	import bpsc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// normal_x, normal_y, normal_z, plane_dist, box_min_x, box_min_y,
	// box_min_z, box_max_x, box_max_y, box_max_z, zero padding.
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// side, zero padding.
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	norm_t     in_norm [AXES];
	coord_t    in_min [AXES];
	coord_t    in_max [AXES];
	coord_t    in_dist;
	coord_t    in_near [AXES];
	coord_t    in_far [AXES];
	axis_t     in_axis;

	logic      valid_s1, valid_s2, valid_s3, valid_s4;
	logic      rdy1, rdy2, rdy3, rdy4;
	bpsc_adv_t adv;

	norm_t     norm_s1 [AXES];
	coord_t    near_s1 [AXES];
	coord_t    far_s1 [AXES];
	coord_t    dist_s1;
	logic      axial_s1;
	coord_t    ax_min_s1;
	coord_t    ax_max_s1;

	logic      axial_s2, axial_s3, axial_s4;
	side_t     ax_side_s2, ax_side_s3, ax_side_s4;
	side_t     side;
	logic      near_ge, far_ge;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			in_norm[i] = s_tdata[i*NORM_WIDTH +: NORM_WIDTH];
			in_min[i]  = s_tdata[OFF_MIN + i*COORD_WIDTH +: COORD_WIDTH];
			in_max[i]  = s_tdata[OFF_MAX + i*COORD_WIDTH +: COORD_WIDTH];
			in_near[i] = in_norm[i][NORM_WIDTH-1] ? in_min[i] : in_max[i];
			in_far[i]  = in_norm[i][NORM_WIDTH-1] ? in_max[i] : in_min[i];
		end
		in_dist = s_tdata[OFF_DIST +: COORD_WIDTH];
		in_axis = AXIS_NONE;
		if (in_norm[0] == ONE_Q) begin
			in_axis = AXIS_X;
		end
		if (in_norm[1] == ONE_Q) begin
			in_axis = AXIS_Y;
		end
		if (in_norm[2] == ONE_Q) begin
			in_axis = AXIS_Z;
		end
	end

	assign rdy4     = ~valid_s4 | m_tready;
	assign rdy3     = ~valid_s3 | rdy4;
	assign rdy2     = ~valid_s2 | rdy3;
	assign rdy1     = ~valid_s1 | rdy2;
	assign s_tready = rdy1;
	assign adv      = '{adv_s2: rdy2, adv_s3: rdy3, adv_s4: rdy4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			norm_s1  <= in_norm;
			near_s1  <= in_near;
			far_s1   <= in_far;
			dist_s1  <= in_dist;
			axial_s1 <= (in_axis != AXIS_NONE);
			case (in_axis)
				AXIS_X: begin
					ax_min_s1 <= in_min[0];
					ax_max_s1 <= in_max[0];
				end
				AXIS_Y: begin
					ax_min_s1 <= in_min[1];
					ax_max_s1 <= in_max[1];
				end
				AXIS_Z: begin
					ax_min_s1 <= in_min[2];
					ax_max_s1 <= in_max[2];
				end
				default: begin
					ax_min_s1 <= in_min[0];
					ax_max_s1 <= in_max[0];
				end
			endcase
		end
		if (rdy2) begin
			axial_s2 <= axial_s1;
			if (dist_s1 <= ax_min_s1) begin
				ax_side_s2 <= SIDE_FRONT;
			end else if (dist_s1 >= ax_max_s1) begin
				ax_side_s2 <= SIDE_BACK;
			end else begin
				ax_side_s2 <= SIDE_BOTH;
			end
		end
		if (rdy3) begin
			axial_s3   <= axial_s2;
			ax_side_s3 <= ax_side_s2;
		end
		if (rdy4) begin
			axial_s4   <= axial_s3;
			ax_side_s4 <= ax_side_s3;
		end
	end

	bpsc_dot u_near (
		.clk        (clk),
		.adv        (adv),
		.norm       (norm_s1),
		.coord      (near_s1),
		.plane_dist (dist_s1),
		.ge         (near_ge)
	);

	bpsc_dot u_far (
		.clk        (clk),
		.adv        (adv),
		.norm       (norm_s1),
		.coord      (far_s1),
		.plane_dist (dist_s1),
		.ge         (far_ge)
	);

	assign side     = axial_s4 ? ax_side_s4 : side_t'({~far_ge, near_ge});
	assign m_tvalid = valid_s4;
	assign m_tdata  = OUT_TDATA_W'(side);

	a_axial_side: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && axial_s4 |-> side != SIDE_NONE)
		else $error("axial plane gave no side");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rdy2 |=> valid_s2)
		else $error("item lost between stage one and stage two");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && valid_s3 && valid_s4)
		else $error("input stalled with a bubble in the pipeline");

	a_s3_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && rdy4 |=> valid_s4)
		else $error("item lost between stage three and stage four");

endmodule

`default_nettype wire

FILE: bench/box_plane_side_classify_tb.sv
// Self-checking testbench for the box versus plane side classifier.
`timescale 1ns / 100ps

module box_plane_side_classify_tb
	import bpsc_pkg::*;
();

	localparam longint Q = 65536;
	localparam longint C_MAX = 64'sd2147483647;
	localparam longint C_MIN = -64'sd2147483648;
	localparam longint N_MAX = 131071;
	localparam longint N_MIN = -131072;
	localparam int LONG_HOLD = 64;

	typedef struct packed {
		coord_t [AXES-1:0] hi;
		coord_t [AXES-1:0] lo;
		coord_t            distance;
		norm_t  [AXES-1:0] nrm;
	} plane_box_t;

	function automatic side_t classify_side(plane_box_t it);
		longint n[AXES];
		longint lo[AXES];
		longint hi[AXES];
		longint d;
		longint near_sum;
		longint far_sum;
		axis_t ax;
		side_t s;
		ax = AXIS_NONE;
		d = $signed(it.distance);
		for (int i = 0; i < AXES; i++) begin
			n[i] = $signed(it.nrm[i]);
			lo[i] = $signed(it.lo[i]);
			hi[i] = $signed(it.hi[i]);
			if (it.nrm[i] == ONE_Q)
				ax = axis_t'(i);
		end
		if (ax != AXIS_NONE) begin
			if (d <= lo[ax])
				s = SIDE_FRONT;
			else if (d >= hi[ax])
				s = SIDE_BACK;
			else
				s = SIDE_BOTH;
		end else begin
			near_sum = -(d * Q);
			far_sum = -(d * Q);
			for (int i = 0; i < AXES; i++) begin
				if (n[i] < 0) begin
					near_sum += n[i] * lo[i];
					far_sum += n[i] * hi[i];
				end else begin
					near_sum += n[i] * hi[i];
					far_sum += n[i] * lo[i];
				end
			end
			s = SIDE_NONE;
			if (near_sum >= 0)
				s = SIDE_FRONT;
			if (far_sum < 0)
				s = side_t'(s | SIDE_BACK);
		end
		return s;
	endfunction

	class side_scoreboard;
		side_t expected_sides[$];
		int unsigned n_errors;
		int unsigned n_checked;
		int unsigned n_by_side[4];

		function void note_plane_box(plane_box_t it);
			expected_sides.push_back(classify_side(it));
		endfunction

		function void check_side(logic [OUT_TDATA_W-1:0] word);
			side_t want;
			if (expected_sides.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result, expected none, actual side %0d",
					$time, word[SIDE_WIDTH-1:0]);
				return;
			end
			want = expected_sides.pop_front();
			n_checked++;
			n_by_side[want]++;
			if (word[SIDE_WIDTH-1:0] !== want) begin
				n_errors++;
				$display("%0t: side mismatch, expected %0d, actual %0d",
					$time, want, word[SIDE_WIDTH-1:0]);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	bit long_hold_req;
	int unsigned hold_left;

	side_scoreboard sb = new;

	box_plane_side_classify i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_plane_box(plane_box_t'(s_tdata[IN_WIDTH-1:0]));
			if (m_tvalid && m_tready)
				sb.check_side(m_tdata);
		end
	end

	initial begin
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint span_rand(longint lo_v, longint hi_v);
		longint unsigned r;
		r = {$urandom, $urandom};
		return lo_v + longint'(r % longint'(hi_v - lo_v + 1));
	endfunction

	function automatic plane_box_t plane_box(longint nx, longint ny, longint nz, longint d,
			longint lx, longint ly, longint lz, longint hx, longint hy, longint hz);
		plane_box_t it;
		it.nrm[0] = norm_t'(nx);
		it.nrm[1] = norm_t'(ny);
		it.nrm[2] = norm_t'(nz);
		it.distance = coord_t'(d);
		it.lo[0] = coord_t'(lx);
		it.lo[1] = coord_t'(ly);
		it.lo[2] = coord_t'(lz);
		it.hi[0] = coord_t'(hx);
		it.hi[1] = coord_t'(hy);
		it.hi[2] = coord_t'(hz);
		return it;
	endfunction

	function automatic plane_box_t rand_plane_box();
		plane_box_t it;
		longint n[AXES];
		longint ctr[AXES];
		longint ext;
		longint lo_v;
		longint hi_v;
		longint dot;
		longint r;
		int unsigned mode;
		int unsigned ax;
		int unsigned win;
		mode = $urandom_range(99);
		if (mode < 15) begin
			it.nrm[0] = norm_t'($urandom);
			it.nrm[1] = norm_t'($urandom);
			it.nrm[2] = norm_t'($urandom);
			it.distance = coord_t'($urandom);
			for (int i = 0; i < AXES; i++) begin
				it.lo[i] = coord_t'($urandom);
				it.hi[i] = coord_t'($urandom);
			end
		end else if (mode < 45) begin
			ax = $urandom_range(2);
			for (int i = 0; i < AXES; i++) begin
				it.nrm[i] = norm_t'($urandom);
				lo_v = span_rand(-(64'sd1 << 30), 64'sd1 << 30);
				ext = span_rand(0, 64'sd1 << $urandom_range(0, 24));
				it.lo[i] = coord_t'(lo_v);
				it.hi[i] = coord_t'(lo_v + ext);
			end
			it.nrm[ax] = ONE_Q;
			if ($urandom_range(3) == 0)
				it.nrm[$urandom_range(2)] = ONE_Q;
			win = ax;
			for (int i = 0; i < AXES; i++)
				if (it.nrm[i] == ONE_Q)
					win = i;
			lo_v = $signed(it.lo[win]);
			hi_v = $signed(it.hi[win]);
			case ($urandom_range(4))
				0: it.distance = coord_t'(lo_v);
				1: it.distance = coord_t'(hi_v);
				2: it.distance = coord_t'(span_rand(lo_v, hi_v));
				3: it.distance = coord_t'(lo_v - span_rand(1, 65536));
				default: it.distance = coord_t'(hi_v + span_rand(1, 65536));
			endcase
		end else begin
			dot = 0;
			for (int i = 0; i < AXES; i++) begin
				if ($urandom_range(3) == 0)
					n[i] = $signed(norm_t'($urandom));
				else
					n[i] = span_rand(-Q, Q);
				ctr[i] = span_rand(-(64'sd1 << 26), 64'sd1 << 26);
				ext = span_rand(0, 64'sd1 << $urandom_range(0, 22));
				lo_v = ctr[i] - ext;
				hi_v = ctr[i] + ext;
				// Inverted boxes exercise the unchecked min above max case.
				if (mode >= 88 && $urandom_range(1) == 1) begin
					lo_v = ctr[i] + ext + 1;
					hi_v = ctr[i] - ext;
				end
				it.nrm[i] = norm_t'(n[i]);
				it.lo[i] = coord_t'(lo_v);
				it.hi[i] = coord_t'(hi_v);
				dot += n[i] * ctr[i];
			end
			r = 64'sd1 << $urandom_range(0, 24);
			it.distance = coord_t'((dot >>> 16) + span_rand(-r, r));
		end
		return it;
	endfunction

	task automatic send_plane_box(input plane_box_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(it);
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_random(input int unsigned count);
		for (int unsigned k = 0; k < count; k++)
			send_plane_box(rand_plane_box());
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		long_hold_req = 1'b0;
		src_idle_pct = 28;
		snk_idle_pct = 50;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_plane_box(plane_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_plane_box(plane_box(N_MAX, N_MAX, N_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
			C_MAX, C_MAX, C_MAX));
		send_plane_box(plane_box(N_MIN, N_MIN, N_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
			C_MIN, C_MIN, C_MIN));
		send_plane_box(plane_box(N_MIN, N_MAX, N_MIN, C_MAX, C_MIN, C_MIN, C_MIN,
			C_MAX, C_MAX, C_MAX));
		send_plane_box(plane_box(N_MAX, N_MIN, N_MAX, C_MIN, C_MIN, C_MIN, C_MIN,
			C_MAX, C_MAX, C_MAX));
		send_plane_box(plane_box(Q, 0, 0, -10 * Q, -10 * Q, 0, 0, 10 * Q, 0, 0));
		send_plane_box(plane_box(Q, 0, 0, 10 * Q, -10 * Q, 0, 0, 10 * Q, 0, 0));
		send_plane_box(plane_box(Q, 0, 0, 3 * Q, -10 * Q, 0, 0, 10 * Q, 0, 0));
		send_plane_box(plane_box(5, Q, -7, -20 * Q, 0, -10 * Q, 0, 0, 10 * Q, 0));
		send_plane_box(plane_box(0, 0, Q, 20 * Q, 0, 0, -10 * Q, 0, 0, 10 * Q));
		send_plane_box(plane_box(Q, 0, Q, 5 * Q, 0, 0, 10 * Q, 20 * Q, 0, 30 * Q));
		send_plane_box(plane_box(Q, Q, Q, 5 * Q, 10 * Q, 0, 0, 20 * Q, 3 * Q, 3 * Q));
		send_plane_box(plane_box(Q, 0, 0, C_MIN, C_MIN, 0, 0, C_MAX, 0, 0));
		send_plane_box(plane_box(Q, 0, 0, C_MAX, C_MIN, 0, 0, C_MAX, 0, 0));
		send_plane_box(plane_box(-Q, 0, 0, 0, -10 * Q, 0, 0, 10 * Q, 0, 0));
		send_plane_box(plane_box(Q - 1, Q + 1, 0, Q, 0, 0, 0, 4 * Q, 4 * Q, 0));
		send_plane_box(plane_box(16384, 0, 0, Q, 0, 0, 0, 4 * Q, 0, 0));
		send_plane_box(plane_box(16384, 0, 0, 0, 0, 0, 0, 4 * Q, 0, 0));
		send_plane_box(plane_box(16384, 0, 0, 4 * Q, 0, 0, 0, 4 * Q, 0, 0));
		send_plane_box(plane_box(32768, 0, 0, 0, 10 * Q, 0, 0, -10 * Q, 0, 0));
		send_plane_box(plane_box(Q, 0, 0, 0, 10 * Q, 0, 0, -10 * Q, 0, 0));
		send_plane_box(plane_box(Q, 0, 0, 20 * Q, 10 * Q, 0, 0, -10 * Q, 0, 0));
		send_plane_box(plane_box(-32768, 32768, -1, 1, 3, -3, 7, -5, 9, -11));
		send_random(280);

		src_idle_pct = 50;
		snk_idle_pct = 28;
		send_random(300);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		send_random(100);
		long_hold_req = 1'b1;
		send_random(200);
		s_tvalid <= 1'b0;

		while (sb.expected_sides.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("Checked %0d transactions: %0d front, %0d back, %0d straddling, %0d none.",
			sb.n_checked, sb.n_by_side[SIDE_FRONT], sb.n_by_side[SIDE_BACK],
			sb.n_by_side[SIDE_BOTH], sb.n_by_side[SIDE_NONE]);
		$display("Axial, general and inverted boxes ran under three idle mixes and a long hold.");
		if (sb.n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
